>>> rtl/core/sbsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

   // work RAM, power-of-two depth; index is the low address bits
   localparam int WRAM_DEPTH = 8192;
   localparam int WRAM_AW    = $clog2(WRAM_DEPTH);

   // shared remainder unit: 5-bit bank number, 7-bit divisor
   localparam int MOD_STEPS = 5;
   localparam int MOD_DVD_W = MOD_STEPS;
   localparam int MOD_DIV_W = 7;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

   localparam logic [1:0] CSR_PRG_BANKS = 2'd0;
   localparam logic [1:0] CSR_CHR_BANKS = 2'd1;
   localparam logic [1:0] CSR_CHR_RAM   = 2'd2;
   localparam logic [1:0] CSR_CHR_LEN   = 2'd3;

   localparam logic [4:0] CTRL_RESET = 5'h0C;

   typedef enum logic [1:0] {
      FUNC_CPU_RD = 2'd0,
      FUNC_CPU_WR = 2'd1,
      FUNC_VID_RD = 2'd2,
      FUNC_VID_WR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_PRG_RD = 2'd1,
      ACT_CHR_RD = 2'd2,
      ACT_CHR_WR = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [MOD_DVD_W-1:0] dividend;
      logic [MOD_DIV_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                 busy;
      logic [MOD_DVD_W-1:0] remainder;
   } mod_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/sbsm_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring remainder, one dividend bit per cycle
module sbsm_mod_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sbsm_pkg::mod_req_type mod_req,
   output sbsm_pkg::mod_rsp_type    mod_rsp
);

   logic                           busy_ff, busy_in;
   logic [sbsm_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [sbsm_pkg::MOD_DVD_W-1:0] dvd_ff, dvd_in;
   logic [sbsm_pkg::MOD_DIV_W-1:0] div_ff, div_in;
   logic [sbsm_pkg::MOD_DIV_W-1:0] rem_ff, rem_in;
   logic [sbsm_pkg::MOD_DIV_W-1:0] trial;

   always_comb begin
      trial   = {rem_ff[sbsm_pkg::MOD_DIV_W-2:0], dvd_ff[sbsm_pkg::MOD_DVD_W-1]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = sbsm_pkg::MOD_CNT_W'(sbsm_pkg::MOD_STEPS);
         dvd_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (trial >= div_ff) ? trial - div_ff : trial;
         dvd_in  = {dvd_ff[sbsm_pkg::MOD_DVD_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != sbsm_pkg::MOD_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   // dividend is at most 5 bits, so the remainder fits in 5 bits
   assign mod_rsp = {busy_ff, rem_ff[sbsm_pkg::MOD_DVD_W-1:0]};

endmodule

`default_nettype wire

>>> rtl/core/serial_bank_switch_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted item passes through the bank remainder unit (ST_DIV) and then ST_DONE,
// which loads the output register once it is empty or being drained. The shared remainder
// unit and sequencer handle one item at a time. A finished item waits in the output register while
// the next item is taken.
// Reset: synchronous; afterwards the work RAM is cleared one entry a cycle
// with req_ready low. csr writes are taken throughout.
module serial_bank_switch_mapper_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_write_data,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_mem_action,
   output logic [17:0]      rsp_mem_offset,
   output logic [1:0]       rsp_mirroring,

   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [18:0] csr_wdata
);

   localparam int AW = sbsm_pkg::WRAM_AW;

   // configuration
   logic [4:0]  prg_banks_ff;
   logic [5:0]  chr_banks_ff;
   logic        chr_is_ram_ff;
   logic [18:0] chr_len_ff;

   // mapper state
   logic [4:0] load_shift_ff, load_shift_in;
   logic [2:0] load_count_ff, load_count_in;
   logic [4:0] ctrl_ff, ctrl_in;
   logic [4:0] chr_low_ff, chr_low_in;
   logic [4:0] chr_high_ff, chr_high_in;
   logic [4:0] prg_bank_ff, prg_bank_in;

   sbsm_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_idx_ff;

   // captured item
   logic [1:0]  func_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff;

   // output register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_rd_ff;
   logic [1:0]  rsp_act_ff;
   logic [17:0] rsp_off_ff;
   logic [1:0]  rsp_mirr_ff;

   // work RAM
   logic [7:0]    wram [sbsm_pkg::WRAM_DEPTH];
   logic [7:0]    ram_rdata_ff;
   logic          ram_we;
   logic [AW-1:0] ram_wa;
   logic [7:0]    ram_wd;

   sbsm_pkg::mod_req_type mod_req;
   sbsm_pkg::mod_rsp_type mod_rsp;

   logic accept, out_load, clr_busy, clr_last;

   logic [4:0] prg_nb;
   logic [4:0] dvd_sel;
   logic [6:0] div_sel;

   logic        ram_on, in_ram, item_ram_we;
   logic [4:0]  bank;
   logic [18:0] prg_sum;
   logic [17:0] prg_off, chr_off, direct_off;
   logic [7:0]  rd_val;
   logic [1:0]  act_val;
   logic [17:0] off_val;

   //------------------------------------------------------------------
   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_banks_ff  <= 5'd1;
         chr_banks_ff  <= '0;
         chr_is_ram_ff <= 1'b0;
         chr_len_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sbsm_pkg::CSR_PRG_BANKS: prg_banks_ff  <= csr_wdata[4:0];
            sbsm_pkg::CSR_CHR_BANKS: chr_banks_ff  <= csr_wdata[5:0];
            sbsm_pkg::CSR_CHR_RAM:   chr_is_ram_ff <= csr_wdata[0];
            sbsm_pkg::CSR_CHR_LEN:   chr_len_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------
   // sequencer
   assign clr_last = (clr_idx_ff == AW'(sbsm_pkg::WRAM_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbsm_pkg::ST_CLEAR: if (clr_last) state_in = sbsm_pkg::ST_IDLE;
         sbsm_pkg::ST_IDLE:  if (req_valid) state_in = sbsm_pkg::ST_DIV;
         sbsm_pkg::ST_DIV:   if (!mod_rsp.busy) state_in = sbsm_pkg::ST_DONE;
         sbsm_pkg::ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = sbsm_pkg::ST_IDLE;
         default:            state_in = sbsm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      clr_busy  = 1'b0;
      unique case (state_ff)
         sbsm_pkg::ST_CLEAR: clr_busy  = 1'b1;
         sbsm_pkg::ST_IDLE:  req_ready = 1'b1;
         sbsm_pkg::ST_DIV:   ;
         sbsm_pkg::ST_DONE:  out_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sbsm_pkg::ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_busy) clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         addr_ff  <= req_address;
         wdata_ff <= req_write_data;
      end
   end

   //------------------------------------------------------------------
   // bank remainder operands, picked from the incoming item
   assign prg_nb = (prg_banks_ff == 5'd0) ? 5'd1 : prg_banks_ff;

   always_comb begin
      dvd_sel = '0;
      div_sel = 7'd1;
      case (sbsm_pkg::func_type'(req_func))
         sbsm_pkg::FUNC_CPU_RD: begin
            div_sel = {2'b00, prg_nb};
            if (ctrl_ff[3] == 1'b0) dvd_sel = {1'b0, prg_bank_ff[3:1], 1'b0};
            else                    dvd_sel = {1'b0, prg_bank_ff[3:0]};
         end
         sbsm_pkg::FUNC_VID_RD: begin
            if (chr_banks_ff != 6'd0 && !chr_is_ram_ff) begin
               if (!ctrl_ff[4]) begin
                  dvd_sel = {1'b0, chr_low_ff[4:1]};
                  div_sel = {1'b0, chr_banks_ff};
               end else begin
                  dvd_sel = (req_address <= 16'h0FFF) ? chr_low_ff : chr_high_ff;
                  div_sel = {chr_banks_ff, 1'b0};
               end
            end
         end
         default: ;
      endcase
   end

   assign mod_req = {accept, dvd_sel, div_sel};

   sbsm_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   //------------------------------------------------------------------
   // result of the captured item
   assign ram_on = !prg_bank_ff[4];
   assign in_ram = (addr_ff >= 16'h6000) && (addr_ff <= 16'h7FFF);

   always_comb begin
      prg_sum = {mod_rsp.remainder, 14'b0} + {4'b0, addr_ff[14:0]};
      if (ctrl_ff[3:2] == 2'd2)
         bank = (addr_ff <= 16'hBFFF) ? 5'd0 : mod_rsp.remainder;
      else
         bank = (addr_ff <= 16'hBFFF) ? mod_rsp.remainder : prg_nb - 5'd1;
      if (ctrl_ff[3] == 1'b0) prg_off = prg_sum[17:0];
      else                    prg_off = {bank[3:0], addr_ff[13:0]};

      direct_off = {5'b0, addr_ff[12:0]};
      if (chr_banks_ff == 6'd0 || chr_is_ram_ff) chr_off = direct_off;
      else if (!ctrl_ff[4])                      chr_off = {mod_rsp.remainder, addr_ff[12:0]};
      else chr_off = {1'b0, mod_rsp.remainder, addr_ff[11:0]};
   end

   always_comb begin
      rd_val      = '0;
      act_val     = sbsm_pkg::ACT_NONE;
      off_val     = '0;
      item_ram_we = 1'b0;
      case (sbsm_pkg::func_type'(func_ff))
         sbsm_pkg::FUNC_CPU_RD: begin
            if (in_ram) begin
               rd_val = ram_on ? ram_rdata_ff : 8'hFF;
            end else begin
               act_val = sbsm_pkg::ACT_PRG_RD;
               off_val = prg_off;
            end
         end
         sbsm_pkg::FUNC_CPU_WR: item_ram_we = in_ram && ram_on;
         sbsm_pkg::FUNC_VID_RD: begin
            if ({1'b0, chr_off} < chr_len_ff) begin
               act_val = sbsm_pkg::ACT_CHR_RD;
               off_val = chr_off;
            end
         end
         sbsm_pkg::FUNC_VID_WR: begin
            if (chr_is_ram_ff && ({1'b0, direct_off} < chr_len_ff)) begin
               act_val = sbsm_pkg::ACT_CHR_WR;
               off_val = direct_off;
            end
         end
         default: ;
      endcase
   end

   // serial load: bit 7 resets, fifth bit commits by address window
   always_comb begin
      load_shift_in = load_shift_ff;
      load_count_in = load_count_ff;
      ctrl_in       = ctrl_ff;
      chr_low_in    = chr_low_ff;
      chr_high_in   = chr_high_ff;
      prg_bank_in   = prg_bank_ff;
      if (out_load && func_ff == sbsm_pkg::FUNC_CPU_WR && addr_ff[15]) begin
         if (wdata_ff[7]) begin
            load_shift_in = '0;
            load_count_in = '0;
            ctrl_in       = ctrl_ff | sbsm_pkg::CTRL_RESET;
         end else begin
            load_shift_in = {wdata_ff[0], load_shift_ff[4:1]};
            load_count_in = load_count_ff + 3'd1;
            if (load_count_ff == 3'd4) begin
               if (addr_ff <= 16'h9FFF)      ctrl_in     = load_shift_in;
               else if (addr_ff <= 16'hBFFF) chr_low_in  = load_shift_in;
               else if (addr_ff <= 16'hDFFF) chr_high_in = load_shift_in;
               else                          prg_bank_in = load_shift_in;
               load_shift_in = '0;
               load_count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_shift_ff <= '0;
         load_count_ff <= '0;
         ctrl_ff       <= sbsm_pkg::CTRL_RESET;
         chr_low_ff    <= '0;
         chr_high_ff   <= '0;
         prg_bank_ff   <= '0;
      end else begin
         load_shift_ff <= load_shift_in;
         load_count_ff <= load_count_in;
         ctrl_ff       <= ctrl_in;
         chr_low_ff    <= chr_low_in;
         chr_high_ff   <= chr_high_in;
         prg_bank_ff   <= prg_bank_in;
      end
   end

   //------------------------------------------------------------------
   // work RAM; read runs every cycle at the captured address
   assign ram_we = clr_busy || (out_load && item_ram_we);
   assign ram_wa = clr_busy ? clr_idx_ff : addr_ff[AW-1:0];
   assign ram_wd = clr_busy ? 8'h00 : wdata_ff;

   always_ff @(posedge clock) begin
      if (ram_we) wram[ram_wa] <= ram_wd;
      ram_rdata_ff <= wram[addr_ff[AW-1:0]];
   end

   //------------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rd_ff   <= rd_val;
         rsp_act_ff  <= act_val;
         rsp_off_ff  <= off_val;
         rsp_mirr_ff <= ctrl_in[1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_rd_ff;
   assign rsp_mem_action = rsp_act_ff;
   assign rsp_mem_offset = rsp_off_ff;
   assign rsp_mirroring  = rsp_mirr_ff;

   //------------------------------------------------------------------
   // checks
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("item taken before work RAM clear");

   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbsm_pkg::ST_IDLE) |-> !mod_rsp.busy)
      else $error("remainder unit busy while sequencer idle");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= 3'd4)
      else $error("serial load count past four");

   a_none_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_act_ff == sbsm_pkg::ACT_NONE) |-> (rsp_off_ff == 18'd0))
      else $error("offset set on item with no memory action");

   a_mem_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_act_ff != sbsm_pkg::ACT_NONE) |-> (rsp_rd_ff == 8'd0))
      else $error("read data set on item with memory action");

endmodule

`default_nettype wire
